[hw/rtl/i2a_pkg.sv]
// Shared types, constants and helpers of the integer to ASCII formatter.
`default_nettype none
package i2a_pkg;

   // Format selector codes; the code above hexadecimal also prints hexadecimal.
   localparam logic [1:0] CMD_SIGNED   = 2'd0;
   localparam logic [1:0] CMD_UNSIGNED = 2'd1;
   localparam logic [1:0] CMD_HEX      = 2'd2;

   // Character source selected for one output character.
   localparam logic [1:0] EMIT_MINUS = 2'd0;
   localparam logic [1:0] EMIT_ZERO  = 2'd1;
   localparam logic [1:0] EMIT_X     = 2'd2;
   localparam logic [1:0] EMIT_DIGIT = 2'd3;

   // ASCII codes.
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_UPPER = 8'h41;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;
   localparam logic [7:0] ASCII_X     = 8'h78;

   // Conversion geometry: 32 binary bits into 10 BCD digits, 4 bits per cycle.
   localparam int BIN_WIDTH     = 32;
   localparam int DEC_DIGITS    = 10;
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS    = BIN_WIDTH / BITS_PER_STEP;
   localparam int CNT_WIDTH     = $clog2(CONV_STEPS);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       conv;
      logic       set_ptr;
      logic       dec_ptr;
      logic       emit;
      logic [1:0] emit_sel;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hex;
      logic neg;
      logic ptr_zero;
   } stat_type;

   // One hexadecimal or decimal digit as an upper-case ASCII character.
   function automatic logic [7:0] digit_ascii(input logic [3:0] nib);
      logic [7:0] res;
      if (nib < 4'd10) begin
         res = ASCII_ZERO + {4'd0, nib};
      end else begin
         res = ASCII_UPPER + {4'd0, nib} - 8'd10;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/i2a_datapath.sv]
// Datapath: operand registers, binary to BCD converter, digit pointer, output register.
`default_nettype none
module i2a_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [1:0]        req_cmd,
   input  wire logic [63:0]       req_value,
   input  wire i2a_pkg::cmd_type  cmd,
   output i2a_pkg::stat_type      stat,
   output logic                   rsp_strobe,
   output logic [7:0]             rsp_ch,
   output logic                   rsp_last
);
   import i2a_pkg::*;

   logic [BIN_WIDTH-1:0]      bin_ff, bin_in;
   logic [63:0]               dig_ff, dig_in;
   logic [3:0]                ptr_ff, ptr_in;
   logic                      hex_ff, hex_in;
   logic                      neg_ff, neg_in;
   logic                      strobe_ff, strobe_in;
   logic [7:0]                ch_ff, ch_in;
   logic                      last_ff, last_in;

   logic [BIN_WIDTH-1:0]      low;
   logic [BIN_WIDTH-1:0]      tb;
   logic [DEC_DIGITS*4-1:0]   td;
   logic [3:0]                top_pos;
   logic [3:0]                cur_nib;

   // Highest nonzero digit; position zero when the whole word is zero.
   always_comb begin
      top_pos = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (dig_ff[i*4 +: 4] != 4'd0) begin
            top_pos = 4'(i);
         end
      end
   end

   // Four double-dabble steps per cycle over the ten BCD digits.
   always_comb begin
      tb = bin_ff;
      td = dig_ff[DEC_DIGITS*4-1:0];
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         for (int d = 0; d < DEC_DIGITS; d++) begin
            if (td[d*4 +: 4] >= 4'd5) begin
               td[d*4 +: 4] = td[d*4 +: 4] + 4'd3;
            end
         end
         td = {td[DEC_DIGITS*4-2:0], tb[BIN_WIDTH-1]};
         tb = {tb[BIN_WIDTH-2:0], 1'b0};
      end
   end

   assign low     = req_value[BIN_WIDTH-1:0];
   assign cur_nib = dig_ff[ptr_ff*4 +: 4];

   // Next-state logic of the operand and digit registers.
   always_comb begin
      bin_in = bin_ff;
      dig_in = dig_ff;
      hex_in = hex_ff;
      neg_in = neg_ff;
      ptr_in = ptr_ff;
      if (cmd.load) begin
         hex_in = req_cmd[1];
         neg_in = (req_cmd == CMD_SIGNED) && low[BIN_WIDTH-1];
         if (req_cmd[1]) begin
            dig_in = req_value;
            bin_in = '0;
         end else begin
            dig_in = '0;
            bin_in = ((req_cmd == CMD_SIGNED) && low[BIN_WIDTH-1]) ? (~low + 1'b1) : low;
         end
      end else if (cmd.conv) begin
         bin_in = tb;
         dig_in = {{(64 - DEC_DIGITS*4){1'b0}}, td};
      end
      if (cmd.set_ptr) begin
         ptr_in = top_pos;
      end else if (cmd.dec_ptr) begin
         ptr_in = ptr_ff - 4'd1;
      end
   end

   // Output character selection.
   always_comb begin
      strobe_in = cmd.emit;
      last_in   = 1'b0;
      case (cmd.emit_sel)
         EMIT_MINUS: ch_in = ASCII_MINUS;
         EMIT_ZERO:  ch_in = ASCII_ZERO;
         EMIT_X:     ch_in = ASCII_X;
         default: begin
            ch_in   = digit_ascii(cur_nib);
            last_in = (ptr_ff == 4'd0);
         end
      endcase
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      dig_ff  <= dig_in;
      ptr_ff  <= ptr_in;
      hex_ff  <= hex_in;
      neg_ff  <= neg_in;
      ch_ff   <= ch_in;
      last_ff <= last_in;
   end

   // Output strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   assign stat.hex      = hex_ff;
   assign stat.neg      = neg_ff;
   assign stat.ptr_zero = (ptr_ff == 4'd0);
   assign rsp_strobe    = strobe_ff;
   assign rsp_ch        = ch_ff;
   assign rsp_last      = last_ff;

endmodule
`default_nettype wire

[hw/rtl/i2a_controller.sv]
// Controller: sequences conversion, prefix and digit output of one request.
`default_nettype none
module i2a_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   output i2a_pkg::cmd_type        cmd,
   input  wire i2a_pkg::stat_type  stat
);
   import i2a_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CONV  = 3'd1;
   localparam logic [2:0] S_SIGN  = 3'd2;
   localparam logic [2:0] S_PFX0  = 3'd3;
   localparam logic [2:0] S_PFXX  = 3'd4;
   localparam logic [2:0] S_DIGIT = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;

   // State transitions and commands.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      cmd.emit_sel = EMIT_DIGIT;
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            if (stat.hex) begin
               cmd.set_ptr = 1'b1;
               state_in    = S_PFX0;
            end else begin
               cmd.conv = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               if (cnt_ff == CNT_WIDTH'(CONV_STEPS - 1)) begin
                  state_in = S_SIGN;
               end
            end
         end
         S_SIGN: begin
            cmd.set_ptr  = 1'b1;
            cmd.emit     = stat.neg;
            cmd.emit_sel = EMIT_MINUS;
            state_in     = S_DIGIT;
         end
         S_PFX0: begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EMIT_ZERO;
            state_in     = S_PFXX;
         end
         S_PFXX: begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EMIT_X;
            state_in     = S_DIGIT;
         end
         S_DIGIT: begin
            cmd.emit    = 1'b1;
            cmd.dec_ptr = 1'b1;
            if (stat.ptr_zero) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
`default_nettype wire

[hw/rtl/integer_to_ascii_formatter.sv]
// Top level of the integer to ASCII formatter.
// A request is taken when start is high and busy is low. Its text leaves one
// character per cycle on rsp_ch, each marked by rsp_strobe for exactly one
// cycle, most significant digit first, with rsp_last on the final character;
// the receiver must take every character as it comes. Decimal requests are
// loaded, converted by a double-dabble unit that takes four bits a cycle,
// pass a sign step that gives a minus sign when negative, then give their
// digits. Hexadecimal requests are loaded, find the leading digit, give the
// 0x prefix and then their digits. busy drops while the final character is
// on the outputs, so the next request may be given in that cycle.
`default_nettype none
module integer_to_ascii_formatter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [63:0] req_value,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_ch,
   output logic             rsp_last
);
   import i2a_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   i2a_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   // Conversion and output datapath.
   i2a_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_cmd    (req_cmd),
      .req_value  (req_value),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_ch     (rsp_ch),
      .rsp_last   (rsp_last)
   );

   // An accepted request makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // The final character leaves only as the block goes idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> !busy)
      else $error("final character while still busy");

   // An idle block emits nothing in the next cycle.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy |=> !rsp_strobe)
      else $error("character emitted without a request in progress");

   // Decimal conversion never runs on a hexadecimal request.
   a_conv_dec: assert property (@(posedge clock) disable iff (reset)
      cmd.conv |-> !stat.hex)
      else $error("conversion step on a hexadecimal request");

endmodule
`default_nettype wire
